// ===== design/igdq_pkg.sv =====
// Package for the int4 group-dequant dot product block.
// Item types, widths and accumulator limits. No dependencies.
package igdq_pkg;

    localparam int NIBBLE_W   = 4;
    localparam int ACT_W      = 16;
    localparam int COEF_W     = 16;
    localparam int DEQ_W      = 20;                 // nibble * scale + offset, exact
    localparam int PROD_W     = DEQ_W + ACT_W;      // one weight-activation product
    localparam int SUM_W      = 48;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [7:0]              weight_byte;
        logic signed [ACT_W-1:0]  activation_even;
        logic signed [ACT_W-1:0]  activation_odd;
        logic signed [COEF_W-1:0] group_scale;
        logic signed [COEF_W-1:0] group_offset;
        logic                     last_of_dot;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] dot_value;
    } t_out_item;

    // dequantized weight pair with its activations, as queued for the back end
    typedef struct packed {
        logic signed [DEQ_W-1:0] weight_even;
        logic signed [DEQ_W-1:0] weight_odd;
        logic signed [ACT_W-1:0] activation_even;
        logic signed [ACT_W-1:0] activation_odd;
        logic                    last_of_dot;
    } t_deq_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

// ===== design/igdq_if.sv =====
// Valid/ready channel interfaces for input and result items.
// Depends on igdq_pkg for the payload types.
interface igdq_in_if import igdq_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface igdq_out_if import igdq_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/igdq_front.sv =====
// Front end: accepts input items and dequantizes both nibbles into a register.
// Depends on igdq_pkg and igdq_in_if; pushes into igdq_fifo.
module igdq_front import igdq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    igdq_in_if.sink          i_in,
    input  t_fifo_status     i_fifo_status,
    output logic             o_push,
    output t_deq_item        o_push_data
);

    logic                    r_valid;
    logic                    n_valid;
    t_deq_item               r_item;
    logic signed [DEQ_W-1:0] deq_even;
    logic signed [DEQ_W-1:0] deq_odd;
    logic                    accept;

    // nibble is unsigned: widen with a zero before the signed multiply
    assign deq_even = $signed({1'b0, i_in.payload.weight_byte[NIBBLE_W-1:0]})
                      * i_in.payload.group_scale + i_in.payload.group_offset;
    assign deq_odd  = $signed({1'b0, i_in.payload.weight_byte[2*NIBBLE_W-1:NIBBLE_W]})
                      * i_in.payload.group_scale + i_in.payload.group_offset;

    assign o_push      = r_valid && !i_fifo_status.full;
    assign o_push_data = r_item;
    assign i_in.ready  = !r_valid || !i_fifo_status.full;
    assign accept      = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.weight_even     <= deq_even;
            r_item.weight_odd      <= deq_odd;
            r_item.activation_even <= i_in.payload.activation_even;
            r_item.activation_odd  <= i_in.payload.activation_odd;
            r_item.last_of_dot     <= i_in.payload.last_of_dot;
        end
    end

endmodule

// ===== design/igdq_fifo.sv =====
// Short queue of dequantized items between front and back end.
// Depends on igdq_pkg.
module igdq_fifo import igdq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_deq_item    i_push_data,
    input  logic         i_pop,
    output t_deq_item    o_pop_data,
    output t_fifo_status o_status
);

    t_deq_item             r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_CNT_W-1:0] n_count;

    assign o_status.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_pop_data     = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== design/igdq_back.sv =====
// Back end: multiplies by the activations, accumulates with saturation and
// holds the result in an output register. Depends on igdq_pkg and igdq_out_if.
module igdq_back import igdq_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_fifo_status  i_fifo_status,
    input  t_deq_item     i_pop_data,
    output logic          o_pop,
    igdq_out_if.source    o_out
);

    logic                     r_s1_valid;
    logic                     n_s1_valid;
    logic                     r_s1_last;
    logic signed [PROD_W-1:0] r_p_even;
    logic signed [PROD_W-1:0] r_p_odd;
    logic signed [PROD_W-1:0] p_even;
    logic signed [PROD_W-1:0] p_odd;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W:0]    acc_full;
    logic signed [SUM_W-1:0]  acc_sat;
    logic                     r_out_valid;
    logic                     n_out_valid;
    t_out_item                r_out;
    logic                     s1_adv;

    assign p_even = i_pop_data.weight_even * i_pop_data.activation_even;
    assign p_odd  = i_pop_data.weight_odd  * i_pop_data.activation_odd;

    // a last item needs room in the output register, others only touch the sum
    assign s1_adv = r_s1_valid && (!r_s1_last || !r_out_valid || o_out.ready);
    assign o_pop  = !i_fifo_status.empty && (!r_s1_valid || s1_adv);

    assign acc_full = r_sum + r_p_even + r_p_odd;

    // clamp when the two top bits disagree
    always_comb begin
        if (acc_full[SUM_W] != acc_full[SUM_W-1]) begin
            acc_sat = acc_full[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            acc_sat = acc_full[SUM_W-1:0];
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (o_pop) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid && !o_out.ready;
        if (s1_adv && r_s1_last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (s1_adv) begin
                r_sum <= r_s1_last ? '0 : acc_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_even  <= p_even;
            r_p_odd   <= p_odd;
            r_s1_last <= i_pop_data.last_of_dot;
        end
        if (s1_adv && r_s1_last) begin
            r_out.dot_value <= acc_sat;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

// ===== design/int4_group_dequant_dot_product.sv =====
// Int4 group-dequantized dot product, top level.
// Instantiates igdq_front, igdq_fifo and igdq_back; uses igdq_pkg and igdq_if.
//
// Takes one packed weight byte with two Q7.8 activations and the Q3.12 scale and
// offset of its group per clock cycle, and returns the exact Q.20 dot product on
// the item marked last_of_dot; the sum saturates at the 48-bit limits if a
// stream runs on too long. Sustained rate is one item per cycle, set by the
// accumulator loop in the back end, while the result side takes results. A
// result passes the dequant register, the queue, the product register and the
// output register after its last item is taken. A four-entry queue between the
// dequant front end and the multiply-accumulate back end lets the input keep
// flowing while a result waits to be taken.
module int4_group_dequant_dot_product import igdq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    igdq_in_if.sink     i_in,
    igdq_out_if.source  o_out
);

    logic         push;
    logic         pop;
    t_deq_item    push_data;
    t_deq_item    pop_data;
    t_fifo_status fifo_status;

    igdq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_fifo_status (fifo_status),
        .o_push        (push),
        .o_push_data   (push_data)
    );

    igdq_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (fifo_status)
    );

    igdq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_status (fifo_status),
        .i_pop_data    (pop_data),
        .o_pop         (pop),
        .o_out         (o_out)
    );

endmodule

// ===== design/igdq_checker.sv =====
// Port-level checker for the int4 group-dequant dot product, bound to the top.
// Depends on igdq_pkg; watches only the top-level channel signals.
module igdq_checker import igdq_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_in_last,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [SUM_W-1:0] i_out_value
);

    localparam int MAX_PENDING = 7;   // front reg + queue + product reg + output reg

    logic [3:0] r_pending;
    logic [3:0] n_pending;
    logic       in_last_acc;
    logic       out_acc;

    assign in_last_acc = i_in_valid && i_in_ready && i_in_last;
    assign out_acc     = i_out_valid && i_out_ready;

    always_comb begin
        n_pending = r_pending;
        if (in_last_acc && !out_acc) begin
            n_pending = r_pending + 1'b1;
        end else if (out_acc && !in_last_acc) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // drop any result after reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a result needs a last-marked item taken before it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_pending != 4'd0))
        else $error("result delivered without a pending last item");

    // hold input back once the pipeline is full of unfinished dot products
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 4'(MAX_PENDING))
        else $error("too many dot products in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("stalled result changed");

endmodule

bind int4_group_dequant_dot_product igdq_checker u_igdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.payload.last_of_dot),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.payload.dot_value)
);

// ===== tb/igdq_checker.sv =====
// Result checker for the int4 group-dequant dot product block.
// Watches both channels, predicts every dot product and compares it with the result item.
// Depends on igdq_pkg and the channel interfaces in igdq_if.
module igdq_scoreboard import igdq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    igdq_in_if    i_in,
    igdq_out_if   i_out,
    output int    o_fail_count,
    output int    o_pending
);

    logic signed [SUM_W-1:0] dot_sum = '0;
    logic signed [SUM_W-1:0] expected_dots[$];
    int                      mismatches = 0;
    int                      pending = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending;

    // Add both weight-activation products of one item to the sum, clamped at 48 bits.
    function automatic logic signed [SUM_W-1:0] dot_accumulate(
        input logic signed [SUM_W-1:0] sum,
        input t_in_item                it
    );
        longint w_even, w_odd, acc;
        w_even = longint'(it.weight_byte[3:0]) * longint'(it.group_scale)
                 + longint'(it.group_offset);
        w_odd  = longint'(it.weight_byte[7:4]) * longint'(it.group_scale)
                 + longint'(it.group_offset);
        acc = longint'(sum) + w_even * longint'(it.activation_even)
              + w_odd * longint'(it.activation_odd);
        if (acc > longint'(SUM_MAX))
            acc = longint'(SUM_MAX);
        if (acc < longint'(SUM_MIN))
            acc = longint'(SUM_MIN);
        return acc[SUM_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            dot_sum = '0;
            expected_dots.delete();
        end else begin
            // take the result first: it never comes from an item accepted at this edge
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                if (expected_dots.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no dot product pending",
                                              i_out.payload.dot_value));
                end else if (i_out.payload.dot_value !== expected_dots[0]) begin
                    report_mismatch($sformatf("dot_value got %0d want %0d",
                                              i_out.payload.dot_value, expected_dots[0]));
                    void'(expected_dots.pop_front());
                end else begin
                    void'(expected_dots.pop_front());
                end
            end
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1) begin
                if (i_in.payload.last_of_dot) begin
                    expected_dots.push_back(dot_accumulate(dot_sum, i_in.payload));
                    dot_sum = '0;
                end else begin
                    dot_sum = dot_accumulate(dot_sum, i_in.payload);
                end
            end
        end
        pending = expected_dots.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the int4 group-dequant dot product testbench: clock, reset, item stimulus,
// result back-pressure and the verdict. Depends on igdq_pkg, igdq_if and igdq_checker.
module tb_top;
    import igdq_pkg::*;

    localparam int HOLD_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n;
    bit   calm_tail = 1'b0;
    bit   held_off = 1'b0;
    int   random_items = 0;
    int   fail_count;
    int   pending;

    igdq_in_if  dot_in ();
    igdq_out_if dot_out ();

    int4_group_dequant_dot_product dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (dot_in),
        .o_out   (dot_out)
    );

    igdq_scoreboard chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (dot_in),
        .i_out        (dot_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_in_item pair_item(input logic [7:0] wb, input logic [15:0] a_even,
                                           input logic [15:0] a_odd, input logic [15:0] scale,
                                           input logic [15:0] offset, input logic last);
        t_in_item it;
        it.weight_byte     = wb;
        it.activation_even = a_even;
        it.activation_odd  = a_odd;
        it.group_scale     = scale;
        it.group_offset    = offset;
        it.last_of_dot     = last;
        return it;
    endfunction

    // Favor the extremes and zero, otherwise any 16-bit value.
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_weights();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one item from a falling edge and return at the falling edge after it is taken.
    task automatic send_item(input t_in_item it);
        if (!calm_tail && $urandom_range(0, 7) == 0) begin
            dot_in.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        dot_in.valid   = 1'b1;
        dot_in.payload = it;
        do @(posedge clk); while (dot_in.ready !== 1'b1);
        @(negedge clk);
    endtask

    // One dot product: scale and offset held per 32-weight group, with occasional noise.
    task automatic send_dot(input int n_items);
        logic [15:0] scale, offset;
        bit          noisy;
        noisy = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < n_items; k++) begin
            if (k % 16 == 0 || (noisy && $urandom_range(0, 3) == 0)) begin
                scale  = pick16();
                offset = pick16();
            end
            send_item(pair_item(pick_weights(), pick16(), pick16(), scale, offset,
                                k == n_items - 1));
            random_items++;
        end
    endtask

    // Run a stream past 4096 items (8192 weights) so the sum clamps, then end it normally.
    task automatic send_overlong(input logic [15:0] act, input int n_items);
        for (int k = 0; k < n_items; k++)
            send_item(pair_item(8'hFF, act, act, 16'h8000, 16'h8000, 1'b0));
        repeat (3)
            send_item(pair_item(pick_weights(), pick16(), pick16(), pick16(), pick16(), 1'b0));
        send_item(pair_item(pick_weights(), pick16(), pick16(), pick16(), pick16(), 1'b1));
    endtask

    // Result side: random stalls, one long hold-off once the random part runs.
    initial begin
        dot_out.ready = 1'b0;
        @(negedge clk);
        forever begin
            if (!held_off && random_items >= 50) begin
                dot_out.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held_off = 1'b1;
            end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
                dot_out.ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            dot_out.ready = 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clk);
        end
    end

    initial begin
        int len;
        int pick;
        int drain;
        bit overlong_done;
        overlong_done  = 1'b0;
        dot_in.valid   = 1'b0;
        dot_in.payload = '0;
        rst_n          = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-item dot products at the field extremes
        send_item(pair_item(8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        send_item(pair_item(8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
        send_item(pair_item(8'hFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
        send_item(pair_item(8'h0F, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1));
        send_item(pair_item(8'hF0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b1));
        send_item(pair_item(8'h00, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 1'b1));
        send_item(pair_item(8'hFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1));
        send_item(pair_item(8'h81, 16'h0001, 16'hFFFF, 16'h1000, 16'hF000, 1'b1));
        // multi-item dot products, scale and offset switching mid-stream
        send_item(pair_item(8'h5A, 16'h1234, 16'hEDCC, 16'h1000, 16'h0000, 1'b0));
        send_item(pair_item(8'hA5, 16'h7FFF, 16'h8000, 16'h1000, 16'h0000, 1'b0));
        send_item(pair_item(8'h3C, 16'h0100, 16'hFF00, 16'hC000, 16'h2000, 1'b0));
        send_item(pair_item(8'hC3, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 1'b0));
        send_item(pair_item(8'h96, 16'h4000, 16'hC000, 16'h0001, 16'hFFFF, 1'b1));
        send_item(pair_item(8'hFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 1'b0));
        send_item(pair_item(8'hFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 1'b1));

        while (random_items < 1000) begin
            if (!overlong_done && random_items >= 400) begin
                send_overlong(16'h8000, $urandom_range(4100, 4160));
                send_overlong(16'h7FFF, $urandom_range(4200, 4260));
                overlong_done = 1'b1;
            end
            if (random_items >= 900)
                calm_tail = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 85)
                len = $urandom_range(1, 16);
            else if (pick < 97)
                len = $urandom_range(17, 128);
            else
                len = $urandom_range(129, 2048);
            send_dot(len);
        end
        dot_in.valid = 1'b0;

        for (drain = 0; drain < 20000 && pending != 0; drain++)
            @(negedge clk);
        repeat (16) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #30000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/igdq_pkg.sv
design/igdq_if.sv
design/igdq_front.sv
design/igdq_fifo.sv
design/igdq_back.sv
design/int4_group_dequant_dot_product.sv
design/igdq_checker.sv
tb/igdq_checker.sv
tb/tb_top.sv
